@@ rtl/sbfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbfr_pkg
// shared types and constants for the six byte frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam logic [7:0] HEAD_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE = 8'h55;

    // completion status of one frame
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TAIL  = 2'd1,
        ST_BAD_CHECK = 2'd2
    } t_frame_status;

    // one completed frame as handed to the output stage
    typedef struct packed {
        logic [7:0]    command;
        logic [7:0]    arg_low;
        logic [7:0]    arg_high;
        t_frame_status status;
    } t_frame;

endpackage

@@ rtl/sbfr_capture.sv @@
// ----------------------------------------------------------------------------
// sbfr_capture
// phase machine and byte capture, builds the frame on the tail byte
// ----------------------------------------------------------------------------
module sbfr_capture
    import sbfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_done,
    output t_frame     o_frame
);

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_CMD  = 6'b000010,
        PH_LO   = 6'b000100,
        PH_HI   = 6'b001000,
        PH_CHK  = 6'b010000,
        PH_TAIL = 6'b100000
    } t_rx_phase;

    t_rx_phase  r_phase, n_phase;
    logic [7:0] r_command;
    logic [7:0] r_arg_low;
    logic [7:0] r_arg_high;
    logic [7:0] r_check;
    logic [7:0] w_sum;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: n_phase = (i_byte == HEAD_BYTE) ? PH_CMD : PH_IDLE;
            PH_CMD:  n_phase = PH_LO;
            PH_LO:   n_phase = PH_HI;
            PH_HI:   n_phase = PH_CHK;
            PH_CHK:  n_phase = PH_TAIL;
            PH_TAIL: n_phase = PH_IDLE;
            default: n_phase = (i_byte == HEAD_BYTE) ? PH_CMD : PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    // captured bytes, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_take && r_phase == PH_CMD) begin
            r_command <= i_byte;
        end
        if (i_take && r_phase == PH_LO) begin
            r_arg_low <= i_byte;
        end
        if (i_take && r_phase == PH_HI) begin
            r_arg_high <= i_byte;
        end
        if (i_take && r_phase == PH_CHK) begin
            r_check <= i_byte;
        end
    end

    assign w_sum = HEAD_BYTE ^ r_command ^ r_arg_low ^ r_arg_high;

    always_comb begin
        o_frame.command  = r_command;
        o_frame.arg_low  = r_arg_low;
        o_frame.arg_high = r_arg_high;
        if (i_byte != TAIL_BYTE) begin
            o_frame.status = ST_BAD_TAIL;
        end else if (w_sum != r_check) begin
            o_frame.status = ST_BAD_CHECK;
        end else begin
            o_frame.status = ST_OK;
        end
    end

    assign o_done = i_take && (r_phase == PH_TAIL);

endmodule

@@ rtl/six_byte_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// six_byte_frame_receiver
// frames a byte stream into six byte packets and reports each one with status
// ----------------------------------------------------------------------------
// One received byte is taken per transfer, and a new byte can be taken in
// every cycle: each byte goes through a single pass of capture logic, and the
// tail byte of a frame loads the output register in the same cycle it is
// taken. A frame is head 0xAA, command, argument low, argument high, checksum
// and tail. Bytes other than 0xAA in idle are dropped without a result. On
// the tail byte one result carries command, both argument bytes and a status:
// ok, bad tail (tail not 0x55, wins over the checksum) or bad checksum (xor of
// 0xAA, command and both arguments differs from the checksum byte). Every
// frame is reported, good or bad, and the receiver returns to idle; 0xAA
// inside a frame is plain data. The result is visible in the cycle after its
// tail byte is taken. Input ready drops only while a result waits in the
// output register and the consumer is not taking it.
// ----------------------------------------------------------------------------
module six_byte_frame_receiver
    import sbfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    // frame result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_command,
    output logic [7:0] o_arg_low,
    output logic [7:0] o_arg_high,
    output logic [1:0] o_frame_status
);

    logic   w_take;       // input transfer this cycle
    logic   w_done;       // tail byte taken, frame complete
    t_frame w_frame;
    logic   r_out_valid;
    t_frame r_out;

    // free when the output slot is empty or being drained this cycle
    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    sbfr_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_rx_byte),
        .o_done  (w_done),
        .o_frame (w_frame)
    );

    // output register: load on frame completion, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_frame;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command      = r_out.command;
    assign o_arg_low      = r_out.arg_low;
    assign o_arg_high     = r_out.arg_high;
    assign o_frame_status = r_out.status;

    // a waiting result that is not taken blocks the input side
    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while result stalled");

    // a new result appears only after a byte transfer
    a_result_from_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_take))
        else $error("result without an input transfer");

    // a frame completes only on an accepted byte
    a_done_needs_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_take)
        else $error("frame completed without transfer");

    // status code stays within its defined values
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status == ST_OK || r_out.status == ST_BAD_TAIL
                         || r_out.status == ST_BAD_CHECK))
        else $error("undefined frame status");

endmodule
